/* rtl/dipu_pkg.sv */
// Package for the decimal integer-part unit: commands, microcode word layout
// and the microprogram ROM. It has no dependencies.
`default_nettype none

package dipu_pkg;

  localparam int unsigned MantWidth = 32;
  localparam int unsigned PcWidth   = 3;
  localparam int unsigned CntWidth  = 5;

  localparam logic [7:0]  MaxScale     = 8'd28;
  localparam logic [3:0]  HalfDigit    = 4'd5;
  localparam logic [31:0] ReservedMask = 32'h7F00FFFF;
  // floor(2^32 / 10), and the reciprocal for an exact divide by five.
  localparam logic [31:0] WordQuot     = 32'd429496729;
  localparam logic [31:0] Div5Recip    = 32'hCCCCCCCD;

  typedef enum logic [1:0] {
    CMD_TRUNC  = 2'd0,
    CMD_NEGATE = 2'd1,
    CMD_ROUND  = 2'd2,
    CMD_FLOOR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DIV    = 2'd2,
    OP_ADJUST = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    JC_JUMP     = 3'd0,
    JC_WAIT_IN  = 3'd1,
    JC_SKIP     = 3'd2,
    JC_LOOP     = 3'd3,
    JC_WAIT_OUT = 3'd4
  } jc_t;

  typedef enum logic [1:0] {
    WORD_LOW  = 2'd0,
    WORD_MID  = 2'd1,
    WORD_HIGH = 2'd2
  } word_t;

  typedef struct packed {
    op_t                 op;
    jc_t                 cond;
    word_t               word;
    logic                first;   // top word: no remainder comes in
    logic                last;    // bottom word: the remainder is a digit
    logic [PcWidth-1:0]  target;
  } ucode_t;

  localparam logic [PcWidth-1:0] PC_IDLE   = 3'd0;
  localparam logic [PcWidth-1:0] PC_DIV    = 3'd2;
  localparam logic [PcWidth-1:0] PC_ADJUST = 3'd5;

  // Microprogram: load, check, three word steps per digit, adjust and hand over.
  function automatic ucode_t ucode_rom(input logic [PcWidth-1:0] pc);
    ucode_t uc;
    uc = '{op: OP_NOP, cond: JC_JUMP, word: WORD_LOW, first: 1'b0, last: 1'b0,
           target: PC_IDLE};
    unique case (pc)
      3'd0: begin
        uc.op   = OP_LOAD;
        uc.cond = JC_WAIT_IN;
      end
      3'd1: begin
        uc.cond   = JC_SKIP;
        uc.target = PC_ADJUST;
      end
      3'd2: begin
        uc.op    = OP_DIV;
        uc.cond  = JC_JUMP;
        uc.word  = WORD_HIGH;
        uc.first = 1'b1;
        uc.target = 3'd3;
      end
      3'd3: begin
        uc.op    = OP_DIV;
        uc.cond  = JC_JUMP;
        uc.word  = WORD_MID;
        uc.target = 3'd4;
      end
      3'd4: begin
        uc.op     = OP_DIV;
        uc.cond   = JC_LOOP;
        uc.word   = WORD_LOW;
        uc.last   = 1'b1;
        uc.target = PC_DIV;
      end
      3'd5: begin
        uc.op     = OP_ADJUST;
        uc.cond   = JC_WAIT_OUT;
        uc.target = PC_IDLE;
      end
      default: begin
        uc.cond   = JC_JUMP;
        uc.target = PC_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

/* rtl/decimal_integer_part_unit_top.sv */
// Decimal integer part unit: a microcoded sequencer driving a 32-bit word
// divide-by-ten datapath. Depends on dipu_pkg.
// Each fractional digit takes three ROM steps, one per mantissa word; scale 0, negate and
// invalid inputs skip the divide loop. One word is processed at a time.
// The result register lets the next word be taken while one waits.
// Reset (synchronous, active high) sends the step counter to idle and clears out_valid.
`default_nettype none

module decimal_integer_part_unit_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] mant_low,
  input  wire logic [31:0] mant_mid,
  input  wire logic [31:0] mant_high,
  input  wire logic [31:0] control_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      res_low,
  output logic [31:0]      res_mid,
  output logic [31:0]      res_high,
  output logic [31:0]      res_control,
  output logic             status
);

  logic [dipu_pkg::PcWidth-1:0]  pc;
  logic [dipu_pkg::PcWidth-1:0]  pc_next;
  dipu_pkg::ucode_t              uc;

  dipu_pkg::cmd_t                cmd;
  logic [31:0]                   ctrl;
  logic                          invalid;
  logic [31:0]                   w_low;
  logic [31:0]                   w_mid;
  logic [31:0]                   w_high;
  logic [3:0]                    rem;
  logic [3:0]                    digit;
  logic                          nz;
  logic [dipu_pkg::CntWidth-1:0] count;

  logic        skip;
  logic        out_free;
  logic [31:0] word_cur;
  logic [3:0]  rem_in;
  logic [32:0] y;
  logic [31:0] half;
  logic [63:0] prod;
  logic [29:0] q_lo;
  logic [33:0] r_full;
  logic [3:0]  rem_out;
  logic [31:0] quot;
  logic        inc;
  logic [95:0] sum;

  assign uc       = dipu_pkg::ucode_rom(pc);
  assign in_ready = (uc.op == dipu_pkg::OP_LOAD);
  assign out_free = !out_valid || out_ready;
  assign skip     = invalid || (cmd == dipu_pkg::CMD_NEGATE) || (ctrl[23:16] == 8'd0);

  always_comb begin
    pc_next = pc;
    unique case (uc.cond)
      dipu_pkg::JC_JUMP:     pc_next = uc.target;
      dipu_pkg::JC_WAIT_IN:  pc_next = in_valid ? pc + 3'd1 : pc;
      dipu_pkg::JC_SKIP:     pc_next = skip ? uc.target : pc + 3'd1;
      dipu_pkg::JC_LOOP:     pc_next = (count != 5'd1) ? uc.target : pc + 3'd1;
      dipu_pkg::JC_WAIT_OUT: pc_next = out_free ? uc.target : pc;
      default:               pc_next = dipu_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dipu_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // One 36-bit by ten step: rem:word = 10*(rem*WordQuot) + (word + 6*rem),
  // and the second part is at most 33 bits, halved then divided by five.
  always_comb begin
    unique case (uc.word)
      dipu_pkg::WORD_HIGH: word_cur = w_high;
      dipu_pkg::WORD_MID:  word_cur = w_mid;
      default:             word_cur = w_low;
    endcase
  end

  assign rem_in  = uc.first ? 4'd0 : rem;
  assign y       = {1'b0, word_cur} + {27'd0, rem_in, 2'b00} + {28'd0, rem_in, 1'b0};
  assign half    = y[32:1];
  assign prod    = 64'(half) * 64'(dipu_pkg::Div5Recip);
  assign q_lo    = prod[63:34];
  assign r_full  = {1'b0, y} - ({1'b0, q_lo, 3'b000} + {3'b000, q_lo, 1'b0});
  assign rem_out = r_full[3:0];
  assign quot    = (dipu_pkg::WordQuot * {28'd0, rem_in}) + {2'b00, q_lo};

  assign inc = ((cmd == dipu_pkg::CMD_ROUND) && (ctrl[23:16] != 8'd0)
                && (digit >= dipu_pkg::HalfDigit))
            || ((cmd == dipu_pkg::CMD_FLOOR) && ctrl[31] && nz);
  assign sum = {w_high, w_mid, w_low} + {95'd0, inc};

  always_ff @(posedge clk) begin
    priority case (uc.op)
      dipu_pkg::OP_LOAD: begin
        if (in_valid) begin
          cmd     <= dipu_pkg::cmd_t'(command);
          ctrl    <= control_word;
          invalid <= (control_word[23:16] > dipu_pkg::MaxScale)
                  || ((control_word & dipu_pkg::ReservedMask) != 32'd0);
          w_low   <= mant_low;
          w_mid   <= mant_mid;
          w_high  <= mant_high;
          digit   <= 4'd0;
          nz      <= 1'b0;
          count   <= control_word[20:16];
          rem     <= 4'd0;
        end
      end
      dipu_pkg::OP_DIV: begin
        rem <= rem_out;
        unique case (uc.word)
          dipu_pkg::WORD_HIGH: w_high <= quot;
          dipu_pkg::WORD_MID:  w_mid  <= quot;
          default:             w_low  <= quot;
        endcase
        if (uc.last) begin
          digit <= rem_out;
          nz    <= nz || (rem_out != 4'd0);
          count <= count - 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: written at the adjust step once the previous word has gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uc.op == dipu_pkg::OP_ADJUST) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uc.op == dipu_pkg::OP_ADJUST) && out_free) begin
      if (invalid) begin
        res_low     <= 32'd0;
        res_mid     <= 32'd0;
        res_high    <= 32'd0;
        res_control <= 32'd0;
        status      <= 1'b1;
      end else begin
        res_low     <= sum[31:0];
        res_mid     <= sum[63:32];
        res_high    <= sum[95:64];
        res_control <= (cmd == dipu_pkg::CMD_NEGATE) ? {~ctrl[31], ctrl[30:0]}
                                                     : {ctrl[31], 31'd0};
        status      <= 1'b0;
      end
    end
  end

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc != 3'd6 && pc != 3'd7)
    else $error("step counter left the microprogram");

  a_rem_digit: assert property (@(posedge clk) disable iff (rst)
    (uc.op == dipu_pkg::OP_DIV) |-> rem_out <= 4'd9)
    else $error("divide step produced a remainder above nine");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (uc.op == dipu_pkg::OP_DIV) |-> count != 5'd0)
    else $error("digit loop running with no digits left");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in progress");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (res_low == 32'd0 && res_mid == 32'd0
                               && res_high == 32'd0 && res_control == 32'd0))
    else $error("invalid input gave a nonzero result");

endmodule

`default_nettype wire

/* dv/tb_decimal_integer_part_unit_top.sv */
// Testbench for decimal_integer_part_unit_top: directed and random decimal words
// under varied handshake pressure, with results checked against a local model.
// Depends on dipu_pkg and the unit's top level only.
`timescale 1ns / 1ps

module tb_decimal_integer_part_unit_top;

  localparam int unsigned MaxCycles  = 600000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 3 * 28 + 10;
  localparam logic [31:0] SignBit    = 32'h8000_0000;

  typedef struct packed {
    dipu_pkg::cmd_t cmd;
    logic [31:0]    lo;
    logic [31:0]    mid;
    logic [31:0]    hi;
    logic [31:0]    ctrl;
  } dec_word_t;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] mid;
    logic [31:0] hi;
    logic [31:0] ctrl;
    logic        status;
  } int_part_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = dipu_pkg::CMD_TRUNC;
  logic [31:0] mant_low = '0;
  logic [31:0] mant_mid = '0;
  logic [31:0] mant_high = '0;
  logic [31:0] control_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] res_low;
  logic [31:0] res_mid;
  logic [31:0] res_high;
  logic [31:0] res_control;
  logic        status;

  dec_word_t   words_to_send[$];
  int_part_t   integer_parts_due[$];
  int unsigned words_queued = 0;
  int unsigned results_seen = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_taken = 1'b0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  decimal_integer_part_unit_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .mant_low     (mant_low),
    .mant_mid     (mant_mid),
    .mant_high    (mant_high),
    .control_word (control_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .res_low      (res_low),
    .res_mid      (res_mid),
    .res_high     (res_high),
    .res_control  (res_control),
    .status       (status)
  );

  always #4 clk = ~clk;

  // Integer part of one decimal word: divide the 96-bit magnitude by ten per scale
  // digit and bump it where rounding or flooring asks; negate flips the sign only.
  function automatic int_part_t integer_part_of(input dec_word_t w);
    int_part_t   r;
    logic [95:0] mag;
    logic [7:0]  scale;
    logic [3:0]  digit;
    logic        dropped;
    logic        sign;
    int          k;
    r       = '0;
    scale   = w.ctrl[23:16];
    sign    = w.ctrl[31];
    mag     = {w.hi, w.mid, w.lo};
    digit   = '0;
    dropped = 1'b0;
    if (scale > dipu_pkg::MaxScale || (w.ctrl & dipu_pkg::ReservedMask) != 32'd0) begin
      r.status = 1'b1;
      return r;
    end
    if (w.cmd == dipu_pkg::CMD_NEGATE) begin
      r.ctrl = w.ctrl ^ SignBit;
    end else begin
      for (k = 0; k < int'(scale); k++) begin
        digit = 4'(mag % 96'd10);
        if (digit != 4'd0) dropped = 1'b1;
        mag = mag / 96'd10;
      end
      // The digit left over from the last pass is the first fractional digit.
      if (w.cmd == dipu_pkg::CMD_ROUND && scale != 8'd0 && digit >= dipu_pkg::HalfDigit) begin
        mag = mag + 96'd1;
      end else if (w.cmd == dipu_pkg::CMD_FLOOR && sign && dropped) begin
        mag = mag + 96'd1;
      end
      r.ctrl = {sign, 31'd0};
    end
    {r.hi, r.mid, r.lo} = mag;
    return r;
  endfunction

  function automatic dec_word_t make_word(input dipu_pkg::cmd_t cmd,
                                          input logic [95:0] mag,
                                          input logic [7:0] scale, input logic neg);
    dec_word_t w;
    w.cmd = cmd;
    {w.hi, w.mid, w.lo} = mag;
    w.ctrl = {neg, 7'd0, scale, 16'd0};
    return w;
  endfunction

  function automatic dec_word_t random_word();
    dec_word_t   w;
    int unsigned pick;
    w.cmd = dipu_pkg::cmd_t'($urandom_range(3));
    case ($urandom_range(7))
      0: begin
        w.lo  = $urandom_range(9999);
        w.mid = '0;
        w.hi  = '0;
      end
      1: begin
        w.lo  = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
        w.mid = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
        w.hi  = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      end
      2: begin
        w.lo  = $urandom;
        w.mid = $urandom_range(1) ? $urandom : 32'd0;
        w.hi  = '0;
      end
      default: begin
        w.lo  = $urandom;
        w.mid = $urandom;
        w.hi  = $urandom;
      end
    endcase
    pick = $urandom_range(99);
    w.ctrl = {1'($urandom_range(1)), 7'd0, 8'($urandom_range(28)), 16'd0};
    if (pick < 7) begin
      w.ctrl[23:16] = 8'($urandom_range(255, 29));
    end else if (pick < 13) begin
      w.ctrl = w.ctrl | ($urandom & dipu_pkg::ReservedMask) | (32'd1 << $urandom_range(15));
    end else if (pick < 15) begin
      w.ctrl = w.ctrl | (32'd1 << $urandom_range(30, 24));
    end
    return w;
  endfunction

  task automatic send_word(input dec_word_t w);
    words_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic wait_all_back();
    while (results_seen < words_queued) @(negedge clk);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    int unsigned i;
    @(posedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < count; i++) send_word(random_word());
    wait_all_back();
  endtask

  // Sender: a new word goes out only once the previous one has been taken.
  always @(negedge clk) begin
    dec_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = words_to_send.pop_front();
        command      <= w.cmd;
        mant_low     <= w.lo;
        mant_mid     <= w.mid;
        mant_high    <= w.hi;
        control_word <= w.ctrl;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that fills the unit up.
  always @(negedge clk) begin
    if (hold_armed && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    dec_word_t w;
    int_part_t exp_r;
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("%0t: run exceeded %0d cycles", $time, MaxCycles);
      $display("TEST FAILED");
      $finish;
    end
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      w.cmd  = dipu_pkg::cmd_t'(command);
      w.lo   = mant_low;
      w.mid  = mant_mid;
      w.hi   = mant_high;
      w.ctrl = control_word;
      integer_parts_due.push_back(integer_part_of(w));
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (integer_parts_due.size() == 0) begin
        $display("%0t: unexpected word: expected none, got %h %h %h ctrl %h status %b",
                 $time, res_high, res_mid, res_low, res_control, status);
        err_count++;
      end else begin
        exp_r = integer_parts_due.pop_front();
        if (res_low !== exp_r.lo) begin
          $display("%0t: res_low expected %h, got %h", $time, exp_r.lo, res_low);
          err_count++;
        end
        if (res_mid !== exp_r.mid) begin
          $display("%0t: res_mid expected %h, got %h", $time, exp_r.mid, res_mid);
          err_count++;
        end
        if (res_high !== exp_r.hi) begin
          $display("%0t: res_high expected %h, got %h", $time, exp_r.hi, res_high);
          err_count++;
        end
        if (res_control !== exp_r.ctrl) begin
          $display("%0t: res_control expected %h, got %h", $time, exp_r.ctrl,
                   res_control);
          err_count++;
        end
        if (status !== exp_r.status) begin
          $display("%0t: status expected %b, got %b", $time, exp_r.status, status);
          err_count++;
        end
      end
    end
  end

  initial begin
    int unsigned i;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: zeros, extremes, rounding and flooring edges, carries.
    for (i = 0; i < 4; i++) send_word(make_word(dipu_pkg::cmd_t'(i), 96'd0, 8'd3, 1'b1));
    for (i = 0; i < 4; i++) send_word(make_word(dipu_pkg::cmd_t'(i), '1, 8'd28, 1'b0));
    send_word(make_word(dipu_pkg::CMD_TRUNC, '1, 8'd0, 1'b1));
    send_word(make_word(dipu_pkg::CMD_ROUND, 96'd15, 8'd1, 1'b0));
    send_word(make_word(dipu_pkg::CMD_ROUND, 96'd14, 8'd1, 1'b1));
    send_word(make_word(dipu_pkg::CMD_ROUND, 96'd149, 8'd2, 1'b0));
    send_word(make_word(dipu_pkg::CMD_FLOOR, 96'd15, 8'd1, 1'b1));
    send_word(make_word(dipu_pkg::CMD_FLOOR, 96'd20, 8'd1, 1'b1));
    send_word(make_word(dipu_pkg::CMD_FLOOR, 96'd19, 8'd1, 1'b0));
    send_word(make_word(dipu_pkg::CMD_NEGATE, 96'd12345, 8'd5, 1'b1));
    // Rounding, then flooring, carry the increment into the middle and then the top mantissa word.
    send_word(make_word(dipu_pkg::CMD_ROUND, 96'h9_FFFF_FFFF, 8'd1, 1'b0));
    send_word(make_word(dipu_pkg::CMD_FLOOR, 96'h9_FFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1));
    send_word(make_word(dipu_pkg::CMD_TRUNC, 96'd77, 8'd29, 1'b0));
    send_word(make_word(dipu_pkg::CMD_NEGATE, '1, 8'd255, 1'b1));
    send_word('{cmd: dipu_pkg::CMD_ROUND, lo: 32'd99, mid: 32'd0, hi: 32'd0,
                ctrl: 32'h0001_0001});
    send_word('{cmd: dipu_pkg::CMD_NEGATE, lo: 32'd5, mid: 32'd0, hi: 32'd0,
                ctrl: 32'h4000_0000});
    send_word('{cmd: dipu_pkg::CMD_FLOOR, lo: '1, mid: '1, hi: '1, ctrl: '1});
    wait_all_back();

    run_random(330, 0, 0);
    run_random(330, 46, 0);
    run_random(330, 0, 46);
    run_random(330, 29, 29);

    // The receiver holds off while the sender keeps offering words.
    @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed     = 1'b1;
    for (i = 0; i < 30; i++) send_word(random_word());
    wait_all_back();

    repeat (DrainWait) @(posedge clk);
    if (err_count == 0 && integer_parts_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0t: %0d mismatches, %0d results outstanding", $time, err_count,
               integer_parts_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
